FILE: rtl/mrpc_pkg.sv
// shared constants, codes and types for the relay pulse controller
package mrpc_pkg;

	localparam int CHANNELS = 8;
	localparam int PinW     = 8;
	localparam int ModeW    = 3;
	localparam int ChanW    = 4;
	localparam int LenW     = 32;
	localparam int CntW     = 32;
	localparam int ActiveW  = 4;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 32;

	typedef enum logic [ModeW-1:0] {
		MODE_ON      = 3'd0,
		MODE_OFF     = 3'd1,
		MODE_TOGGLE  = 3'd2,
		MODE_PULSE   = 3'd3,
		MODE_ALL_ON  = 3'd4,
		MODE_ALL_OFF = 3'd5,
		MODE_TICK    = 3'd6,
		MODE_QUERY   = 3'd7
	} mode_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_ACTIVE      = 2'd0,
		CFG_POLARITY    = 2'd1,
		CFG_PULSE_MODE  = 2'd2,
		CFG_DEFAULT_LEN = 2'd3
	} cfg_idx_t;

	// action handed to one channel cell
	typedef enum logic [2:0] {
		ACT_NONE   = 3'd0,
		ACT_ON     = 3'd1,
		ACT_OFF    = 3'd2,
		ACT_TOGGLE = 3'd3,
		ACT_PULSE  = 3'd4,
		ACT_TICK   = 3'd5
	} act_t;

	typedef struct packed {
		logic [ActiveW-1:0] active_channels;
		logic [PinW-1:0]    polarity_mask;
		logic [PinW-1:0]    pulse_mode_mask;
		logic [LenW-1:0]    default_pulse_ms;
	} cfg_t;

	typedef struct packed {
		act_t            act;
		logic            live;
		logic            mode_bit;
		logic [LenW-1:0] pulse_ms;
		logic [LenW-1:0] dflt_ms;
	} chan_ctl_t;

	typedef struct packed {
		logic            on_q;
		logic            on_n;
		logic [CntW-1:0] cnt_n;
		logic            changed;
	} chan_st_t;

endpackage

FILE: rtl/mrpc_if.sv
// command and result channel interfaces
interface mrpc_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [mrpc_pkg::ModeW-1:0]  mode;
	logic [mrpc_pkg::ChanW-1:0]  channel;
	logic [mrpc_pkg::LenW-1:0]   pulse_ms;

	modport source (output valid, mode, channel, pulse_ms, input ready);
	modport sink   (input valid, mode, channel, pulse_ms, output ready);
endinterface

interface mrpc_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       status;
	logic                       channel_on;
	logic [mrpc_pkg::CntW-1:0]  switch_count;
	logic [mrpc_pkg::PinW-1:0]  pin_levels;
	logic [mrpc_pkg::PinW-1:0]  changed_mask;

	modport source (output valid, status, channel_on, switch_count, pin_levels, changed_mask,
		input ready);
	modport sink   (input valid, status, channel_on, switch_count, pin_levels, changed_mask,
		output ready);
endinterface

FILE: rtl/mrpc_cfg.sv
// configuration register file
module mrpc_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mrpc_pkg::CfgIdxW-1:0]   cfg_idx,
	input  logic [mrpc_pkg::CfgDataW-1:0]  cfg_data,
	output mrpc_pkg::cfg_t                 cfg
);

	mrpc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_channels  <= mrpc_pkg::ActiveW'(mrpc_pkg::CHANNELS);
			cfg_q.polarity_mask    <= '0;
			cfg_q.pulse_mode_mask  <= '0;
			cfg_q.default_pulse_ms <= '0;
		end else if (cfg_we) begin
			unique case (mrpc_pkg::cfg_idx_t'(cfg_idx))
				mrpc_pkg::CFG_ACTIVE:
					cfg_q.active_channels  <= cfg_data[mrpc_pkg::ActiveW-1:0];
				mrpc_pkg::CFG_POLARITY:
					cfg_q.polarity_mask    <= cfg_data[mrpc_pkg::PinW-1:0];
				mrpc_pkg::CFG_PULSE_MODE:
					cfg_q.pulse_mode_mask  <= cfg_data[mrpc_pkg::PinW-1:0];
				mrpc_pkg::CFG_DEFAULT_LEN:
					cfg_q.default_pulse_ms <= cfg_data[mrpc_pkg::LenW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/mrpc_chan.sv
// one relay channel: on bit, switch count, pulse override and countdown
module mrpc_chan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  mrpc_pkg::chan_ctl_t   ctl,
	output mrpc_pkg::chan_st_t    st
);

	logic                       on_q, on_n;
	logic [mrpc_pkg::CntW-1:0]  cnt_q, cnt_n;
	logic                       ovr_q, ovr_n;
	logic [mrpc_pkg::LenW-1:0]  len_q, len_n;
	logic [mrpc_pkg::LenW-1:0]  rem_q, rem_n;
	logic                       do_on, do_off;
	logic                       arm;
	logic [mrpc_pkg::LenW-1:0]  arm_len;

	always_comb begin
		on_n   = on_q;
		cnt_n  = cnt_q;
		ovr_n  = ovr_q;
		len_n  = len_q;
		rem_n  = rem_q;
		do_on  = 1'b0;
		do_off = 1'b0;
		case (ctl.act)
			mrpc_pkg::ACT_ON:     do_on = 1'b1;
			mrpc_pkg::ACT_OFF:    do_off = 1'b1;
			mrpc_pkg::ACT_TOGGLE: begin
				do_on  = !on_q;
				do_off = on_q;
			end
			mrpc_pkg::ACT_PULSE: begin
				ovr_n = 1'b1;
				len_n = ctl.pulse_ms;
				do_on = 1'b1;
			end
			mrpc_pkg::ACT_TICK: begin
				// armed countdown steps down; expiry drops a live channel
				if (rem_q != '0) begin
					rem_n = rem_q - 1'b1;
					if (rem_q == mrpc_pkg::LenW'(1) && ctl.live) begin
						on_n = 1'b0;
					end
				end
			end
			default: ;
		endcase
		arm     = ovr_n | ctl.mode_bit;
		arm_len = ovr_n ? len_n : ctl.dflt_ms;
		if (do_on) begin
			if (!on_q) begin
				on_n  = 1'b1;
				cnt_n = cnt_q + 1'b1;
			end
			if (arm && arm_len != '0) begin
				rem_n = arm_len;
			end
		end
		if (do_off) begin
			on_n  = 1'b0;
			rem_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q  <= 1'b0;
			cnt_q <= '0;
			ovr_q <= 1'b0;
			len_q <= '0;
			rem_q <= '0;
		end else if (en) begin
			on_q  <= on_n;
			cnt_q <= cnt_n;
			ovr_q <= ovr_n;
			len_q <= len_n;
			rem_q <= rem_n;
		end
	end

	assign st.on_q    = on_q;
	assign st.on_n    = on_n;
	assign st.cnt_n   = cnt_n;
	assign st.changed = on_n ^ on_q;

endmodule

FILE: rtl/multi_channel_relay_pulse_controller_core.sv
// top level of the multi-channel relay controller with one-shot pulse mode
//
// Takes one command word per clock, unless a stalled result holds it back:
// on, off, toggle, pulse, all on, all off, a 1 ms tick or a query, and
// returns exactly one result word per command with the status, the
// addressed channel's on bit and off-to-on count, the pin levels after
// polarity and the mask of channels that switched. A command sits in the
// input register while the per-channel update is worked out, and the
// result register then takes it; a new command can be taken every cycle
// while the result word is not stalled, the rate being set by the
// combinational update of the channel cells. A stalled result word holds
// the input register and the channel state until it is taken.
// Configuration writes are only legal with no command in flight.
module multi_channel_relay_pulse_controller_core (
	input  logic                           clk,
	input  logic                           arst_n,
	mrpc_cmd_if.sink                       cmd,
	mrpc_rsp_if.source                     rsp,
	input  logic                           cfg_we,
	input  logic [mrpc_pkg::CfgIdxW-1:0]   cfg_idx,
	input  logic [mrpc_pkg::CfgDataW-1:0]  cfg_data
);

	localparam int N = mrpc_pkg::CHANNELS;

	mrpc_pkg::cfg_t cfg;

	// input stage
	logic                        valid_s1;
	logic [mrpc_pkg::ModeW-1:0]  mode_s1;
	logic [mrpc_pkg::ChanW-1:0]  chan_s1;
	logic [mrpc_pkg::LenW-1:0]   plen_s1;

	// result register
	logic                        rsp_valid_q;
	logic                        status_q;
	logic                        on_q;
	logic [mrpc_pkg::CntW-1:0]   cnt_q;
	logic [mrpc_pkg::PinW-1:0]   pins_q;
	logic [mrpc_pkg::PinW-1:0]   changed_q;

	logic                        advance;
	logic                        upd_en;
	logic                        addressed;
	logic                        chan_ok;
	logic [N-1:0]                sel;
	logic [N-1:0]                live;
	logic [N-1:0]                mode_bits;
	mrpc_pkg::chan_ctl_t         ctl [N];
	mrpc_pkg::chan_st_t          st  [N];

	logic                        status_c;
	logic                        on_c;
	logic [mrpc_pkg::CntW-1:0]   cnt_c;
	logic [mrpc_pkg::PinW-1:0]   pins_c;
	logic [mrpc_pkg::PinW-1:0]   changed_c;
	logic [mrpc_pkg::PinW-1:0]   pins_now;

	mrpc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	// handshake: the result register frees up when empty or being taken
	assign advance   = !rsp_valid_q || rsp.ready;
	assign cmd.ready = !valid_s1 || advance;
	assign upd_en    = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			mode_s1 <= cmd.mode;
			chan_s1 <= cmd.channel;
			plen_s1 <= cmd.pulse_ms;
		end
	end

	// channel addressing: one-based, bounded by active count and channel count
	assign addressed = (mrpc_pkg::mode_t'(mode_s1) == mrpc_pkg::MODE_ON)
		|| (mrpc_pkg::mode_t'(mode_s1) == mrpc_pkg::MODE_OFF)
		|| (mrpc_pkg::mode_t'(mode_s1) == mrpc_pkg::MODE_TOGGLE)
		|| (mrpc_pkg::mode_t'(mode_s1) == mrpc_pkg::MODE_PULSE)
		|| (mrpc_pkg::mode_t'(mode_s1) == mrpc_pkg::MODE_QUERY);
	assign chan_ok = (chan_s1 != '0) && (int'(chan_s1) <= int'(cfg.active_channels))
		&& (int'(chan_s1) <= N);

	for (genvar i = 0; i < N; i++) begin : g_chan
		assign sel[i]  = chan_ok && (int'(chan_s1) == i + 1);
		assign live[i] = int'(cfg.active_channels) > i;

		// per-channel command decode
		always_comb begin
			ctl[i].act      = mrpc_pkg::ACT_NONE;
			ctl[i].live     = live[i];
			ctl[i].mode_bit = mode_bits[i];
			ctl[i].pulse_ms = plen_s1;
			ctl[i].dflt_ms  = cfg.default_pulse_ms;
			unique case (mrpc_pkg::mode_t'(mode_s1))
				mrpc_pkg::MODE_ON:
					if (sel[i]) ctl[i].act = mrpc_pkg::ACT_ON;
				mrpc_pkg::MODE_OFF:
					if (sel[i]) ctl[i].act = mrpc_pkg::ACT_OFF;
				mrpc_pkg::MODE_TOGGLE:
					if (sel[i]) ctl[i].act = mrpc_pkg::ACT_TOGGLE;
				mrpc_pkg::MODE_PULSE:
					if (sel[i]) ctl[i].act = mrpc_pkg::ACT_PULSE;
				mrpc_pkg::MODE_ALL_ON:
					if (live[i]) ctl[i].act = mrpc_pkg::ACT_ON;
				mrpc_pkg::MODE_ALL_OFF:
					if (live[i]) ctl[i].act = mrpc_pkg::ACT_OFF;
				mrpc_pkg::MODE_TICK:
					ctl[i].act = mrpc_pkg::ACT_TICK;
				mrpc_pkg::MODE_QUERY: ;
				default: ;
			endcase
		end

		// set-up pulse mode bits exist only for the first eight channels
		if (i < mrpc_pkg::PinW) begin : g_mb
			assign mode_bits[i] = cfg.pulse_mode_mask[i];
		end else begin : g_nomb
			assign mode_bits[i] = 1'b0;
		end

		mrpc_chan u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (upd_en),
			.ctl    (ctl[i]),
			.st     (st[i])
		);
	end

	// pins and change mask cover channels one to eight only
	for (genvar b = 0; b < mrpc_pkg::PinW; b++) begin : g_pin
		if (b < N) begin : g_used
			assign pins_c[b]    = st[b].on_n ^ cfg.polarity_mask[b];
			assign pins_now[b]  = st[b].on_q ^ cfg.polarity_mask[b];
			assign changed_c[b] = st[b].changed;
		end else begin : g_unused
			assign pins_c[b]    = 1'b0;
			assign pins_now[b]  = 1'b0;
			assign changed_c[b] = 1'b0;
		end
	end

	// addressed channel readout, one-hot select
	always_comb begin
		on_c  = 1'b0;
		cnt_c = '0;
		for (int i = 0; i < N; i++) begin
			if (addressed && sel[i]) begin
				on_c  = on_c | st[i].on_n;
				cnt_c = cnt_c | st[i].cnt_n;
			end
		end
		status_c = addressed && !chan_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_en) begin
			status_q  <= status_c;
			on_q      <= on_c;
			cnt_q     <= cnt_c;
			pins_q    <= pins_c;
			changed_q <= status_c ? '0 : changed_c;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.channel_on   = on_q;
	assign rsp.switch_count = cnt_q;
	assign rsp.pin_levels   = pins_q;
	assign rsp.changed_mask = changed_q;

`ifndef SYNTHESIS
	// a rejected channel number never reports a count or a switch
	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status |-> rsp.switch_count == '0 && rsp.changed_mask == '0
		&& !rsp.channel_on)
		else $error("error result carries channel data");

	// a waiting result matches the channel state it left behind
	a_pins_match: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.pin_levels == pins_now)
		else $error("pin levels disagree with channel state");

	// no channel state moves while the result register is blocked
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> $stable(pins_now) && $stable(valid_s1))
		else $error("state changed during a stall");

	// a command in the input stage always yields a result next cycle when free
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		upd_en |=> rsp_valid_q)
		else $error("command dropped");
`endif

endmodule
